@@ rtl/tkl_pkg.sv @@
// shared widths, beat type and coefficient tables for the type k linearizer
// no dependencies
package tkl_pkg;

  localparam int unsigned IN_W     = 16;
  localparam int unsigned R_W      = 13;
  localparam int unsigned XQ_W     = 22;
  localparam int unsigned H_W      = 40;
  localparam int unsigned PROD_W   = H_W + XQ_W + 1;
  localparam int unsigned TEMP_W   = 11;
  localparam int unsigned K_W      = 4;
  localparam int unsigned N_STEPS  = 9;

  localparam logic [IN_W-1:0]   READING_MAX = 16'd5489;
  localparam logic [R_W-1:0]    BAND_EDGE   = 13'd2064;
  localparam logic [TEMP_W-1:0] TEMP_MAX    = 11'd1372;

  // x in Q6.16 millivolts: floor((r * 2^16 + 50) / 100) by reciprocal
  localparam int unsigned   RECIP_SHIFT = 36;
  localparam int unsigned   N_W         = 29;
  localparam int unsigned   M_W         = 30;
  localparam logic [M_W-1:0] RECIP_MUL  = 30'd687194768;
  localparam logic [N_W-1:0] RECIP_BIAS = 29'd50;

  localparam int unsigned SHIFT_LOW  = 21;
  localparam int unsigned SHIFT_HIGH = 22;

  typedef struct packed {
    logic [XQ_W-1:0]       xq;
    logic                  high;
    logic                  ovr;
    logic signed [H_W-1:0] h;
  } tkl_beat_t;

  // high band padded with zeros above its top term
  function automatic logic signed [H_W-1:0] coef(logic high, logic [K_W-1:0] k);
    logic signed [H_W-1:0] c;
    c = '0;
    if (high) begin
      case (k)
        4'd0:    c = -40'sd8638025;
        4'd1:    c =  40'sd202594195;
        4'd2:    c = -40'sd441853083;
        4'd3:    c =  40'sd938833640;
        4'd4:    c = -40'sd1061107330;
        4'd5:    c =  40'sd619399267;
        4'd6:    c = -40'sd140098428;
        default: c = '0;
      endcase
    end else begin
      case (k)
        4'd0:    c =  40'sd0;
        4'd1:    c =  40'sd52604017;
        4'd2:    c =  40'sd5274828;
        4'd3:    c = -40'sd537543289;
        4'd4:    c =  40'sd5714210030;
        4'd5:    c = -40'sd27004753700;
        4'd6:    c =  40'sd68989770100;
        4'd7:    c = -40'sd99372601300;
        4'd8:    c =  40'sd76217767200;
        4'd9:    c = -40'sd24274877570;
        default: c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

@@ rtl/tkl_scale.sv @@
// input stage: saturation, band choice and scaling of the reading to q6.16 mv
// depends on tkl_pkg
module tkl_scale import tkl_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  logic [IN_W-1:0] reading_i,
  output logic            valid_o,
  input  logic            stall_i,
  output tkl_beat_t       beat_o
);

  logic                  valid_q;
  tkl_beat_t             beat_q, beat_d;
  logic                  ovr;
  logic [R_W-1:0]        r;
  logic [N_W-1:0]        n;
  logic [N_W+M_W-1:0]    prod;
  logic                  high;

  always_comb begin
    ovr  = reading_i > READING_MAX;
    r    = ovr ? READING_MAX[R_W-1:0] : reading_i[R_W-1:0];
    n    = {r, 16'd0} + RECIP_BIAS;
    prod = (N_W+M_W)'(n) * (N_W+M_W)'(RECIP_MUL);
    high = r >= BAND_EDGE;
    beat_d.xq   = prod[RECIP_SHIFT +: XQ_W];
    beat_d.high = high;
    beat_d.ovr  = ovr;
    beat_d.h    = coef(high, K_W'(N_STEPS));
  end

  assign stall_o = valid_q & stall_i;
  assign valid_o = valid_q;
  assign beat_o  = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

  a_ovr_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && beat_q.ovr |-> beat_q.high)
    else $error("saturated reading outside high band");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> valid_q)
    else $error("accepted beat lost at scale stage");

endmodule

@@ rtl/tkl_horner.sv @@
// one horner step: h = c_k + round(h * x / 2^s), one multiplier per stage
// depends on tkl_pkg
module tkl_horner import tkl_pkg::*; #(
  parameter int unsigned K = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      stall_o,
  input  tkl_beat_t beat_i,
  output logic      valid_o,
  input  logic      stall_i,
  output tkl_beat_t beat_o
);

  localparam logic [K_W-1:0] KI = K_W'(K);

  logic                     valid_q;
  tkl_beat_t                beat_q, beat_d;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] biased;
  logic signed [PROD_W-1:0] shifted;
  logic signed [H_W:0]      acc;

  always_comb begin
    prod    = PROD_W'(beat_i.h) * $signed({1'b0, beat_i.xq});
    biased  = prod + (beat_i.high ? PROD_W'(64'd1 << (SHIFT_HIGH - 1))
                                  : PROD_W'(64'd1 << (SHIFT_LOW - 1)));
    shifted = beat_i.high ? (biased >>> SHIFT_HIGH) : (biased >>> SHIFT_LOW);
    acc     = shifted[H_W:0] + (H_W+1)'(coef(beat_i.high, KI));
    beat_d      = beat_i;
    beat_d.h    = acc[H_W-1:0];
  end

  assign stall_o = valid_q & stall_i;
  assign valid_o = valid_q;
  assign beat_o  = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && stall_i |=> valid_q && $stable(beat_q))
    else $error("horner stage dropped a held beat");

endmodule

@@ rtl/tkl_round.sv @@
// output stage: round to whole degrees and clamp to the table range
// depends on tkl_pkg
module tkl_round import tkl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  tkl_beat_t         beat_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [TEMP_W-1:0] temp_o,
  output logic              ovr_o
);

  localparam int unsigned T_W = H_W - 15;

  logic                  valid_q;
  logic [TEMP_W-1:0]     temp_q, temp_d;
  logic                  ovr_q;
  logic signed [H_W:0]   biased;
  logic signed [T_W-1:0] t;

  always_comb begin
    biased = (H_W+1)'(beat_i.h) + (H_W+1)'(32768);
    t      = T_W'(biased >>> 16);
    if (t < 0) begin
      temp_d = '0;
    end else if (t > T_W'(TEMP_MAX)) begin
      temp_d = TEMP_MAX;
    end else begin
      temp_d = t[TEMP_W-1:0];
    end
  end

  assign stall_o = valid_q & stall_i;
  assign valid_o = valid_q;
  assign temp_o  = temp_q;
  assign ovr_o   = ovr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      temp_q <= temp_d;
      ovr_q  <= beat_i.ovr;
    end
  end

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> temp_q <= TEMP_MAX)
    else $error("temperature beyond clamp");

endmodule

@@ rtl/type_k_thermocouple_linearizer_top.sv @@
// top level of the type k thermocouple linearizer
// depends on tkl_pkg, tkl_scale, tkl_horner, tkl_round
//
//   channel  dir  handshake                  payload
//   in       in   in_valid_i / in_stall_o    reading_10uv_i[15:0]
//   out      out  out_valid_o / out_stall_i  temp_celsius_o[10:0], over_range_o
//
// registered stages: scaling, nine horner steps, rounding; one beat per cycle unless stalled
// one multiplier per horner stage, all stages in a chain
// each stage holds its beat under stall and fills when empty, so bubbles close up
// reset clears only the stage valid bits; no state is kept between beats
module type_k_thermocouple_linearizer_top import tkl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [IN_W-1:0]   reading_10uv_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [TEMP_W-1:0] temp_celsius_o,
  output logic              over_range_o
);

  logic      valid [N_STEPS+1];
  logic      stall [N_STEPS+1];
  tkl_beat_t beat  [N_STEPS+1];

  tkl_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .stall_o   (in_stall_o),
    .reading_i (reading_10uv_i),
    .valid_o   (valid[0]),
    .stall_i   (stall[0]),
    .beat_o    (beat[0])
  );

  for (genvar i = 0; i < N_STEPS; i++) begin : g_step
    tkl_horner #(
      .K (N_STEPS - 1 - i)
    ) u_horner (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[i]),
      .stall_o (stall[i]),
      .beat_i  (beat[i]),
      .valid_o (valid[i+1]),
      .stall_i (stall[i+1]),
      .beat_o  (beat[i+1])
    );
  end

  tkl_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[N_STEPS]),
    .stall_o (stall[N_STEPS]),
    .beat_i  (beat[N_STEPS]),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .temp_o  (temp_celsius_o),
    .ovr_o   (over_range_o)
  );

endmodule
